// File: sv/cstp_pkg.sv
// shared types, constants and register codes for the coulomb sum block
package cstp_pkg;

  localparam int COORD_FRAC_BITS_DEF = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CSUB_W = 38;
  localparam int SQ_STEPS = 5;
  localparam int ROOT_STEPS = 34;
  localparam int DIV_STEPS = 64;

  localparam logic [31:0] REF_RESET = 32'h0033_0000;
  localparam logic [31:0] MIN_DIST_RESET = 32'd7;
  localparam logic [63:0] SUM_MAX = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] SUM_MIN = 64'h8000_0000_0000_0000;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_REF_X = 3'd0;
  localparam cfg_idx_t REG_REF_Y = 3'd1;
  localparam cfg_idx_t REG_REF_Z = 3'd2;
  localparam cfg_idx_t REG_MIN_DIST = 3'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ,
    ST_ROOT,
    ST_CHECK,
    ST_DIV,
    ST_SIGN,
    ST_DONE
  } eng_state_t;

  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] charge;
    logic        last;
  } item_t;

  typedef struct packed {
    logic [31:0] ref_x;
    logic [31:0] ref_y;
    logic [31:0] ref_z;
    logic [31:0] min_dist;
  } ref_t;

  typedef struct packed {
    logic [63:0] term;
    logic        last;
  } res_t;

endpackage

// File: sv/coulomb_sum_to_point.sv
// top level: configuration registers, saturating accumulator and result register
//
// Usage: one particle per input transfer (in_pos_x/y/z Q15.16, in_particle_charge
// Q7.24, in_is_last). The block adds charge / distance to the configured reference
// point into a saturating Q31.32 sum. On a particle with in_is_last set it presents
// out_total and out_saturated on the result channel and clears the sum.
// A particle passes through the squared-distance, 34-step root and 64-step divide
// steps, the root and divide sharing one compare and subtract unit; the divide is
// skipped when the particle is below the distance threshold or at zero distance.
// in_ready is high only while the engine is idle, so one particle is taken at a time
// and a new particle is not taken until the previous one has left the engine.
// A last particle raises out_valid once its term is taken into the result register.
// The result register lets the next particles start while a result waits; a
// finished last particle holds in the engine until the previous result is taken.
// Reset (rst_n low, synchronous) returns the reference point to 51.0 on each axis,
// the threshold to 7, clears the sum and saturation flag and drops out_valid.
// cfg_we writes cfg_wdata to register cfg_index (0..3); other indices are ignored.
// Write configuration only while the block is idle.
module coulomb_sum_to_point import cstp_pkg::*; #(
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic signed [31:0] in_particle_charge,
  input  logic               in_is_last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [63:0] out_total,
  output logic               out_saturated,
  input  logic               cfg_we,
  input  cfg_idx_t           cfg_index,
  input  logic [31:0]        cfg_wdata
);

  ref_t        refs_r;
  logic [63:0] sum_r;
  logic        sat_r;
  logic        out_valid_r;
  logic [63:0] out_total_r;
  logic        out_sat_r;

  item_t       item;
  res_t        res;
  logic        res_valid, res_ready;
  logic [63:0] sum_add, sum_new;
  logic        ovf;

  assign item.pos_x  = in_pos_x;
  assign item.pos_y  = in_pos_y;
  assign item.pos_z  = in_pos_z;
  assign item.charge = in_particle_charge;
  assign item.last   = in_is_last;

  cstp_engine #(
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (item),
    .refs      (refs_r),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // a last term waits while the result register is still occupied
  assign res_ready = !(res.last && out_valid_r && !out_ready);

  always_comb begin
    sum_add = sum_r + res.term;
    ovf     = (sum_r[63] == res.term[63]) && (sum_add[63] != sum_r[63]);
    if (ovf) begin
      sum_new = sum_r[63] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_new = sum_add;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      refs_r.ref_x    <= REF_RESET;
      refs_r.ref_y    <= REF_RESET;
      refs_r.ref_z    <= REF_RESET;
      refs_r.min_dist <= MIN_DIST_RESET;
      sum_r           <= '0;
      sat_r           <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_REF_X:    refs_r.ref_x    <= cfg_wdata;
          REG_REF_Y:    refs_r.ref_y    <= cfg_wdata;
          REG_REF_Z:    refs_r.ref_z    <= cfg_wdata;
          REG_MIN_DIST: refs_r.min_dist <= cfg_wdata;
          default: ;
        endcase
      end
      if (res_valid && res_ready && res.last) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (res_valid && res_ready) begin
        if (res.last) begin
          sum_r <= '0;
          sat_r <= 1'b0;
        end else begin
          sum_r <= sum_new;
          sat_r <= sat_r | ovf;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready && res.last) begin
      out_total_r <= sum_new;
      out_sat_r   <= sat_r | ovf;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_total     = out_total_r;
  assign out_saturated = out_sat_r;

  a_last_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_ready && res.last) |=> out_valid_r)
    else $error("last term transfer did not load the result register");

  a_last_clears_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_ready && res.last) |=> (sum_r == '0 && !sat_r))
    else $error("sum not cleared after last term");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> $stable(out_total_r))
    else $error("pending result overwritten");

endmodule

// File: sv/cstp_csub.sv
// shared compare and subtract unit for root and quotient steps
module cstp_csub import cstp_pkg::*; (
  input  logic [CSUB_W-1:0] a,
  input  logic [CSUB_W-1:0] b,
  output logic              ge,
  output logic [CSUB_W-1:0] diff
);

  logic [CSUB_W:0] wide;

  assign wide = {1'b0, a} - {1'b0, b};
  assign ge   = ~wide[CSUB_W];
  assign diff = wide[CSUB_W-1:0];

endmodule

// File: sv/cstp_engine.sv
// sequenced datapath: squared distance, integer root and charge over distance
module cstp_engine import cstp_pkg::*; #(
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  input  ref_t  refs,
  output logic  res_valid,
  input  logic  res_ready,
  output res_t  res
);

  localparam int SHIFT = COORD_FRAC_BITS + 8;

  eng_state_t state_r, state_nxt;
  logic [5:0]  cnt_r;
  logic [31:0] pos_x_r, pos_y_r, pos_z_r;
  logic [31:0] mag_r;
  logic        neg_r;
  logic        last_r;
  logic [31:0] diff_r;
  logic [63:0] prod_r;
  logic [67:0] rad_r;
  logic [35:0] rem_r;
  logic [33:0] root_r;
  logic [63:0] dvd_r;
  logic [63:0] term_r;
  logic        skip_r;

  logic [31:0] pa, pb, ua, ub, ad;
  logic        skip;
  logic [CSUB_W-1:0] cs_a, cs_b, cs_diff;
  logic        cs_ge;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_SQ;
      ST_SQ:    if (cnt_r == 6'(SQ_STEPS - 1)) state_nxt = ST_ROOT;
      ST_ROOT:  if (cnt_r == 6'(ROOT_STEPS - 1)) state_nxt = ST_CHECK;
      ST_CHECK: state_nxt = skip ? ST_SIGN : ST_DIV;
      ST_DIV:   if (cnt_r == 6'(DIV_STEPS - 1)) state_nxt = ST_SIGN;
      ST_SIGN:  state_nxt = ST_DONE;
      ST_DONE:  if (res_ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    res_valid = (state_r == ST_DONE);
    res.term  = term_r;
    res.last  = last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_nxt != state_r) begin
        cnt_r <= '0;
      end else begin
        cnt_r <= cnt_r + 6'd1;
      end
    end
  end

  // axis select and absolute difference in offset binary
  always_comb begin
    case (cnt_r[1:0])
      2'd0: begin
        pa = pos_x_r;
        pb = refs.ref_x;
      end
      2'd1: begin
        pa = pos_y_r;
        pb = refs.ref_y;
      end
      default: begin
        pa = pos_z_r;
        pb = refs.ref_z;
      end
    endcase
    ua = pa ^ 32'h8000_0000;
    ub = pb ^ 32'h8000_0000;
    ad = (ua >= ub) ? (ua - ub) : (ub - ua);
  end

  always_comb begin
    if (state_r == ST_DIV) begin
      cs_a = {3'b0, rem_r[33:0], dvd_r[63]};
      cs_b = {4'b0, root_r};
    end else begin
      cs_a = {rem_r, rad_r[67:66]};
      cs_b = {2'b0, root_r, 2'b01};
    end
  end

  cstp_csub u_csub (
    .a    (cs_a),
    .b    (cs_b),
    .ge   (cs_ge),
    .diff (cs_diff)
  );

  assign skip = (root_r == '0) || (root_r < {2'b0, refs.min_dist});

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          pos_x_r <= in_item.pos_x;
          pos_y_r <= in_item.pos_y;
          pos_z_r <= in_item.pos_z;
          neg_r   <= in_item.charge[31];
          mag_r   <= in_item.charge[31] ? (32'd0 - in_item.charge) : in_item.charge;
          last_r  <= in_item.last;
          rad_r   <= '0;
          rem_r   <= '0;
          root_r  <= '0;
        end
      end
      ST_SQ: begin
        if (cnt_r < 6'd3) diff_r <= ad;
        if (cnt_r >= 6'd1 && cnt_r <= 6'd3) prod_r <= diff_r * diff_r;
        if (cnt_r >= 6'd2) rad_r <= rad_r + {4'b0, prod_r};
      end
      ST_ROOT: begin
        rad_r  <= {rad_r[65:0], 2'b00};
        rem_r  <= cs_ge ? cs_diff[35:0] : cs_a[35:0];
        root_r <= {root_r[32:0], cs_ge};
      end
      ST_CHECK: begin
        skip_r <= skip;
        dvd_r  <= {32'b0, mag_r} << SHIFT;
        rem_r  <= '0;
      end
      ST_DIV: begin
        rem_r <= cs_ge ? cs_diff[35:0] : cs_a[35:0];
        dvd_r <= {dvd_r[62:0], cs_ge};
      end
      ST_SIGN: begin
        if (skip_r) begin
          term_r <= '0;
        end else begin
          term_r <= neg_r ? (64'd0 - dvd_r) : dvd_r;
        end
      end
      default: ;
    endcase
  end

  a_root_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROOT) |-> (rem_r <= {1'b0, root_r, 1'b0}))
    else $error("root remainder above twice the partial root");

  a_div_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rem_r < {2'b0, root_r}))
    else $error("division remainder not below divisor");

  a_root_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROOT) |-> (cnt_r < 6'(ROOT_STEPS)))
    else $error("root step count overrun");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (root_r != '0))
    else $error("division entered with zero distance");

endmodule
